### hw/rtl/ptw_pkg.sv
// Package for the two-level page table walker: field widths, register
// indexes, operation and status codes, sequencer state type.
// No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int unsigned FRAME_W    = 20;  // frame and virtual page number
  localparam int unsigned IDX_W      = 10;  // index into one node
  localparam int unsigned ENTRY_W    = FRAME_W + 1;  // frame plus valid bit
  localparam int unsigned ROOT_W     = 4;
  localparam int unsigned FREE_W     = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'b1;

  localparam logic [ROOT_W-1:0] ROOT_RESET = 4'd0;
  localparam logic [FREE_W-1:0] FREE_RESET = 5'd1;

  // operation codes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_MAP   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAME = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,  // clearing pass over table memory
    S_IDLE,
    S_ROOT,   // reducing the root frame
    S_LOOK0,  // level-0 entry on the read port
    S_NODE,   // reducing the level-1 node frame
    S_WR1,    // level-1 write after allocation
    S_LOOK1,  // level-1 entry on the read port
    S_RESP    // waiting for the output register
  } ptw_state_e;

endpackage

`default_nettype wire

### hw/rtl/ptw_if.sv
// Handshake channel interfaces for the walker: request and response.
// Depends on ptw_pkg.
`default_nettype none

interface ptw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ptw_pkg::FRAME_W-1:0]   virtual_page;
  logic                          unmap;
  logic [ptw_pkg::FRAME_W-1:0]   physical_frame;

  modport source (output valid, operation, virtual_page, unmap, physical_frame,
                  input ready);
  modport sink   (input valid, operation, virtual_page, unmap, physical_frame,
                  output ready);
endinterface

interface ptw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          mapped;
  logic [ptw_pkg::FRAME_W-1:0]   frame_out;
  logic [ptw_pkg::STATUS_W-1:0]  status;

  modport source (output valid, mapped, frame_out, status, input ready);
  modport sink   (input valid, mapped, frame_out, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/ptw_table_mem.sv
// Single-port synchronous table memory with a registered read.
// Depends on ptw_pkg.
`default_nettype none

module ptw_table_mem #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DEPTH  = 16384
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [ADDR_W-1:0]             addr_i,
  input  wire logic [ptw_pkg::ENTRY_W-1:0]   wdata_i,
  output logic      [ptw_pkg::ENTRY_W-1:0]   rdata_o
);

  logic [ptw_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [ptw_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ptw_frame_mod.sv
// Reduces a 20-bit frame number modulo the table frame count: reciprocal
// multiply, back-multiply, one correction. Pipelined.
// Depends on ptw_pkg.
`default_nettype none

module ptw_frame_mod #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ptw_pkg::FRAME_W-1:0]       value_i,
  output logic                                   done_o,
  output logic [$clog2(TABLE_FRAMES)-1:0]        frame_o
);

  localparam int unsigned FW      = $clog2(TABLE_FRAMES);
  localparam int unsigned XW      = ptw_pkg::FRAME_W;
  localparam int unsigned SHIFT   = XW + FW;
  localparam int unsigned RECIP_W = XW + 2;
  localparam int unsigned PROD_W  = XW + RECIP_W;
  localparam int unsigned TW      = XW + FW + 1;
  // floor(2^SHIFT / T): quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << SHIFT) / TABLE_FRAMES);
  localparam logic [TW-1:0]      DIV   = TW'(TABLE_FRAMES);

  logic              v1_q, v2_q, done_q;
  logic [XW-1:0]     x1_q, x2_q;
  logic [PROD_W-1:0] prod_q;
  logic [TW-1:0]     qt_q;
  logic [FW-1:0]     frame_q;
  logic [XW-1:0]     quot;
  logic [TW-1:0]     rem, rem_fix;

  always_comb begin
    quot    = XW'(prod_q >> SHIFT);
    rem     = TW'(x2_q) - qt_q;
    rem_fix = (rem >= DIV) ? rem - DIV : rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= value_i;
    prod_q  <= {{RECIP_W{1'b0}}, value_i} * {{XW{1'b0}}, RECIP};
    x2_q    <= x1_q;
    qt_q    <= TW'(quot) * DIV;
    frame_q <= rem_fix[FW-1:0];
  end

  assign done_o  = done_q;
  assign frame_o = frame_q;

endmodule

`default_nettype wire

### hw/rtl/two_level_page_table_walker_top.sv
// Two-level page table walker. After reset the block runs a clearing pass over
// every table entry (one table entry per cycle) and takes no request until it
// ends; configuration writes are taken throughout. Requests are then handled one
// at a time by a sequencer around a single-port table memory with a registered
// read. The root frame and every frame read from a level-0 entry go through the
// modulo unit. A query takes two reductions and two reads, an unmap of an
// existing node two reductions, two reads and a write, a map into an existing
// node two reductions, one read and one write, a map that allocates a node one
// reduction, one read and two writes, and a level-0 miss one reduction and one
// read. The result sits in an output register, so the next request is taken while it waits.
// Depends on ptw_pkg, ptw_if, ptw_frame_mod and ptw_table_mem.
`default_nettype none

module two_level_page_table_walker_top #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ptw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  ptw_req_if.sink                               req_i,
  ptw_rsp_if.source                             rsp_o
);

  localparam int unsigned FW     = $clog2(TABLE_FRAMES);
  localparam int unsigned IW     = ptw_pkg::IDX_W;
  localparam int unsigned XW     = ptw_pkg::FRAME_W;
  localparam int unsigned EW     = ptw_pkg::ENTRY_W;
  localparam int unsigned ADDR_W = FW + IW;
  localparam int unsigned DEPTH  = TABLE_FRAMES << IW;
  localparam int unsigned UW     = $clog2(TABLE_FRAMES + 1);  // frames_used
  localparam int unsigned NW     = ((UW > ptw_pkg::FREE_W) ? UW : ptw_pkg::FREE_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [NW-1:0]     LIMIT     = NW'(TABLE_FRAMES);

  ptw_pkg::ptw_state_e state_q, state_d;

  // control state
  logic [ADDR_W-1:0]           clr_q;
  logic [ptw_pkg::ROOT_W-1:0]  root_frame_q;
  logic [ptw_pkg::FREE_W-1:0]  first_free_q;
  logic [UW-1:0]               frames_used_q;
  logic                        rsp_valid_q;

  // request and walk payload
  logic                        op_q, unmap_q;
  logic [XW-1:0]               vpn_q, ppn_q;
  logic [FW-1:0]               root_f_q, node_f_q;
  logic                        res_mapped_q;
  logic [XW-1:0]               res_frame_q;
  logic [ptw_pkg::STATUS_W-1:0] res_status_q;
  logic                        out_mapped_q;
  logic [XW-1:0]               out_frame_q;
  logic [ptw_pkg::STATUS_W-1:0] out_status_q;

  // memory and modulo unit
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [EW-1:0]     mem_wdata, mem_rdata;
  logic              mod_start, mod_done;
  logic [XW-1:0]     mod_value;
  logic [FW-1:0]     mod_frame;

  // decoded conditions
  logic [IW-1:0] idx0, idx1;
  logic [NW-1:0] nf;
  logic          is_map, ent_valid, no_frame, rsp_free;

  // sequencer outputs
  logic                         req_ready, capture, root_f_en, node_f_en, alloc;
  logic [FW-1:0]                node_f_val;
  logic                         res_load, res_mapped_n, rsp_load;
  logic [XW-1:0]                res_frame_n;
  logic [ptw_pkg::STATUS_W-1:0] res_status_n;

  assign idx0      = vpn_q[XW-1:IW];
  assign idx1      = vpn_q[IW-1:0];
  assign nf        = NW'(first_free_q) + NW'(frames_used_q);
  assign is_map    = (op_q == ptw_pkg::OP_UPDATE) && !unmap_q;
  assign ent_valid = mem_rdata[0];
  assign no_frame  = (nf >= LIMIT);
  assign rsp_free  = !rsp_valid_q || rsp_o.ready;

  ptw_table_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  ptw_frame_mod #(
    .TABLE_FRAMES (TABLE_FRAMES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_value),
    .done_o  (mod_done),
    .frame_o (mod_frame)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptw_pkg::S_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ptw_pkg::S_IDLE;
      end
      ptw_pkg::S_IDLE: begin
        if (req_i.valid) state_d = ptw_pkg::S_ROOT;
      end
      ptw_pkg::S_ROOT: begin
        if (mod_done) state_d = ptw_pkg::S_LOOK0;
      end
      ptw_pkg::S_LOOK0: begin
        if (ent_valid) begin
          state_d = ptw_pkg::S_NODE;
        end else if (is_map && !no_frame) begin
          state_d = ptw_pkg::S_WR1;
        end else begin
          state_d = ptw_pkg::S_RESP;
        end
      end
      ptw_pkg::S_NODE: begin
        if (mod_done) state_d = is_map ? ptw_pkg::S_RESP : ptw_pkg::S_LOOK1;
      end
      ptw_pkg::S_WR1:   state_d = ptw_pkg::S_RESP;
      ptw_pkg::S_LOOK1: state_d = ptw_pkg::S_RESP;
      ptw_pkg::S_RESP: begin
        if (rsp_free) state_d = ptw_pkg::S_IDLE;
      end
      default: state_d = ptw_pkg::S_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_ready    = 1'b0;
    capture      = 1'b0;
    root_f_en    = 1'b0;
    node_f_en    = 1'b0;
    node_f_val   = mod_frame;
    alloc        = 1'b0;
    mem_we       = 1'b0;
    mem_addr     = {node_f_q, idx1};
    mem_wdata    = {ppn_q, 1'b1};
    mod_start    = 1'b0;
    mod_value    = mem_rdata[EW-1:1];
    res_load     = 1'b0;
    res_mapped_n = 1'b0;
    res_frame_n  = '0;
    res_status_n = ptw_pkg::STATUS_DONE;
    rsp_load     = 1'b0;
    case (state_q)
      ptw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      ptw_pkg::S_IDLE: begin
        req_ready = 1'b1;
        capture   = req_i.valid;
        mod_start = req_i.valid;
        mod_value = XW'(root_frame_q);
      end
      ptw_pkg::S_ROOT: begin
        mem_addr  = {mod_frame, idx0};
        root_f_en = mod_done;
      end
      ptw_pkg::S_LOOK0: begin
        mem_addr = {root_f_q, idx0};
        if (ent_valid) begin
          mod_start = 1'b1;
        end else if (op_q == ptw_pkg::OP_QUERY) begin
          res_load     = 1'b1;
          res_status_n = ptw_pkg::STATUS_NO_MAP;
        end else if (unmap_q) begin
          // no level-1 node: nothing to clear
          res_load = 1'b1;
        end else if (no_frame) begin
          res_load     = 1'b1;
          res_status_n = ptw_pkg::STATUS_NO_FRAME;
        end else begin
          // allocate a node and hook it into level 0
          mem_we     = 1'b1;
          mem_wdata  = {XW'(nf), 1'b1};
          alloc      = 1'b1;
          node_f_en  = 1'b1;
          node_f_val = nf[FW-1:0];
        end
      end
      ptw_pkg::S_NODE: begin
        mem_addr  = {mod_frame, idx1};
        node_f_en = mod_done;
        if (mod_done && is_map) begin
          mem_we   = 1'b1;
          res_load = 1'b1;
        end
      end
      ptw_pkg::S_WR1: begin
        mem_we   = 1'b1;
        res_load = 1'b1;
      end
      ptw_pkg::S_LOOK1: begin
        res_load = 1'b1;
        if (op_q == ptw_pkg::OP_QUERY) begin
          res_mapped_n = ent_valid;
          res_frame_n  = ent_valid ? mem_rdata[EW-1:1] : '0;
          res_status_n = ent_valid ? ptw_pkg::STATUS_DONE : ptw_pkg::STATUS_NO_MAP;
        end else begin
          // unmap: drop the valid bit, keep the frame
          mem_we    = 1'b1;
          mem_wdata = {mem_rdata[EW-1:1], 1'b0};
        end
      end
      ptw_pkg::S_RESP: begin
        rsp_load = rsp_free;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ptw_pkg::S_CLEAR;
      clr_q         <= '0;
      root_frame_q  <= ptw_pkg::ROOT_RESET;
      first_free_q  <= ptw_pkg::FREE_RESET;
      frames_used_q <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ptw_pkg::S_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ptw_pkg::CFG_ROOT_FRAME: root_frame_q <= cfg_wdata_i[ptw_pkg::ROOT_W-1:0];
          ptw_pkg::CFG_FIRST_FREE: first_free_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (alloc) frames_used_q <= frames_used_q + UW'(1);
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (capture) begin
      op_q    <= req_i.operation;
      vpn_q   <= req_i.virtual_page;
      unmap_q <= req_i.unmap;
      ppn_q   <= req_i.physical_frame;
    end
    if (root_f_en) root_f_q <= mod_frame;
    if (node_f_en) node_f_q <= node_f_val;
    if (res_load) begin
      res_mapped_q <= res_mapped_n;
      res_frame_q  <= res_frame_n;
      res_status_q <= res_status_n;
    end
    if (rsp_load) begin
      out_mapped_q <= res_mapped_q;
      out_frame_q  <= res_frame_q;
      out_status_q <= res_status_q;
    end
  end

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.mapped    = out_mapped_q;
  assign rsp_o.frame_out = out_frame_q;
  assign rsp_o.status    = out_status_q;

  // node count never passes the table size
  a_frames_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_used_q <= UW'(TABLE_FRAMES))
    else $error("allocation count beyond table frames");

  // modulo unit only answers a reduction the sequencer is waiting for
  a_mod_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == ptw_pkg::S_ROOT || state_q == ptw_pkg::S_NODE))
    else $error("frame reduction finished outside a wait state");

  // allocation write only with a frame left
  a_alloc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ptw_pkg::S_LOOK0 && mem_we) |-> (nf < LIMIT))
    else $error("node allocated past the last table frame");

  // a mapped result always reports success
  a_mapped_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.mapped) |-> (rsp_o.status == ptw_pkg::STATUS_DONE))
    else $error("mapped result with failure status");

endmodule

`default_nettype wire
